// ----- design/crng_pkg.sv -----
// shared constants, types and a modular reduction function for the shuffled combined generator
package crng_pkg;

    // default shuffle table depth
    localparam int TABLE_DEPTH_DEF = 32;

    // generator word and product widths
    localparam int GEN_W  = 31;
    localparam int MUL_W  = 16;
    localparam int PROD_W = GEN_W + MUL_W;

    // moduli, multipliers and folding constants (modulus = 2^31 - fold)
    localparam logic [GEN_W-1:0] MOD1         = 31'd2147483563;
    localparam logic [GEN_W-1:0] MOD2         = 31'd2147483399;
    localparam logic [GEN_W-1:0] MOD1_LESS1   = 31'd2147483562;
    localparam logic [MUL_W-1:0] MUL1         = 16'd40014;
    localparam logic [MUL_W-1:0] MUL2         = 16'd40692;
    localparam logic [7:0]       FOLD1        = 8'd85;
    localparam logic [7:0]       FOLD2        = 8'd249;
    localparam logic [GEN_W-1:0] SECOND_RESET = 31'd123456789;

    // slot index by reciprocal multiplication
    localparam int SLOT_SHIFT   = 40;
    localparam int SLOT_RECIP_W = 16;
    localparam int SLOT_Q_W     = 7;
    localparam int SLOT_PROD_W  = GEN_W + SLOT_RECIP_W;

    typedef logic [GEN_W-1:0]  gen_t;
    typedef logic [PROD_W-1:0] prod_t;

    // transaction function codes
    typedef enum logic {
        FUNC_DRAW   = 1'b0,
        FUNC_RESEED = 1'b1
    } func_t;

    // table port control between sequencer and table memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } tbl_ctrl_t;

    // reduce a 47-bit product modulo 2^31 - fold: hi*fold + lo stays below twice the modulus
    function automatic gen_t fold_reduce(input prod_t p, input logic [7:0] fold,
                                         input gen_t modulus);
        logic [GEN_W:0] s;
        s = {1'b0, p[GEN_W-1:0]}
            + ({{(GEN_W+1-MUL_W){1'b0}}, p[PROD_W-1:GEN_W]} * {{(GEN_W-7){1'b0}}, fold});
        if (s >= {1'b0, modulus})
        begin
            s = s - {1'b0, modulus};
        end
        return s[GEN_W-1:0];
    endfunction

endpackage

// ----- design/crng_gen_unit.sv -----
// step unit for both congruential generators: registered multiply, then fold and reduce
module crng_gen_unit (
    input  logic              clk,
    input  crng_pkg::gen_t    first_gen,
    input  crng_pkg::gen_t    second_gen,
    output crng_pkg::gen_t    first_step,
    output crng_pkg::gen_t    second_step
);

    crng_pkg::prod_t prod1_reg;
    crng_pkg::prod_t prod2_reg;
    crng_pkg::prod_t prod1_next;
    crng_pkg::prod_t prod2_next;

    // product stage
    assign prod1_next = crng_pkg::PROD_W'(first_gen) * crng_pkg::PROD_W'(crng_pkg::MUL1);
    assign prod2_next = crng_pkg::PROD_W'(second_gen) * crng_pkg::PROD_W'(crng_pkg::MUL2);

    always_ff @(posedge clk)
    begin
        prod1_reg <= prod1_next;
        prod2_reg <= prod2_next;
    end

    // reduction stage
    assign first_step  = crng_pkg::fold_reduce(prod1_reg, crng_pkg::FOLD1, crng_pkg::MOD1);
    assign second_step = crng_pkg::fold_reduce(prod2_reg, crng_pkg::FOLD2, crng_pkg::MOD2);

endmodule

// ----- design/crng_slot_unit.sv -----
// slot index from the previous output: divide by a constant via reciprocal and one correction
module crng_slot_unit #(
    parameter int TABLE_DEPTH = crng_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           clk,
    input  crng_pkg::gen_t                 last_output,
    output logic [$clog2(TABLE_DEPTH)-1:0] slot
);

    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int SLOT_DIV = 1 + 2147483562 / TABLE_DEPTH;
    localparam longint RECIP = (64'd1 << crng_pkg::SLOT_SHIFT) / SLOT_DIV;
    localparam int QD_W     = crng_pkg::SLOT_Q_W + crng_pkg::GEN_W;
    localparam logic [crng_pkg::SLOT_RECIP_W-1:0] RECIP_L = crng_pkg::SLOT_RECIP_W'(RECIP);
    localparam logic [crng_pkg::GEN_W-1:0] DIV_L = crng_pkg::GEN_W'(SLOT_DIV);
    localparam logic [crng_pkg::SLOT_Q_W-1:0] LAST_SLOT = crng_pkg::SLOT_Q_W'(TABLE_DEPTH - 1);

    logic [crng_pkg::SLOT_PROD_W-1:0] prod_reg;
    logic [crng_pkg::SLOT_PROD_W-1:0] prod_next;
    logic [crng_pkg::SLOT_Q_W-1:0]    q0_reg;
    logic [crng_pkg::SLOT_Q_W-1:0]    q0_next;
    logic [crng_pkg::GEN_W-1:0]       rem_reg;
    logic [QD_W-1:0]                  qd;
    logic [QD_W-1:0]                  rem_next;
    logic [crng_pkg::SLOT_Q_W-1:0]    q;

    // estimate: quotient is exact or one short
    assign prod_next = crng_pkg::SLOT_PROD_W'(last_output)
                       * crng_pkg::SLOT_PROD_W'(RECIP_L);
    assign q0_next   = prod_reg[crng_pkg::SLOT_PROD_W-1:crng_pkg::SLOT_SHIFT];
    assign qd        = QD_W'(q0_next) * QD_W'(DIV_L);
    assign rem_next  = QD_W'(last_output) - qd;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        q0_reg   <= q0_next;
        rem_reg  <= rem_next[crng_pkg::GEN_W-1:0];
    end

    // correction and clamp to last slot
    always_comb
    begin
        q = q0_reg + crng_pkg::SLOT_Q_W'(rem_reg >= DIV_L);
        if (q > LAST_SLOT)
        begin
            q = LAST_SLOT;
        end
    end

    assign slot = q[IDX_W-1:0];

endmodule

// ----- design/crng_table.sv -----
// shuffle table memory with per-entry valid bits so unwritten entries read as zero
module crng_table #(
    parameter int TABLE_DEPTH = crng_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  crng_pkg::tbl_ctrl_t            ctrl,
    input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    input  crng_pkg::gen_t                 wr_data,
    output crng_pkg::gen_t                 rd_data
);

    crng_pkg::gen_t          mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  valid_reg;
    crng_pkg::gen_t          rd_mem_reg;
    logic                    rd_valid_reg;

    // valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctrl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // storage with registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_mem_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_mem_reg : '0;

endmodule

// ----- design/combined_lcg_shuffle_rng.sv -----
// Combined two-generator random source with a shuffle table held in a small memory.
// Each transaction on the input gives exactly one draw on the output. A plain draw
// (func 0) goes from acceptance to a loaded result through the shared multiply/reduce
// unit that steps both generators (multiply, then reduce), while the table slot is
// formed from the previous output alongside, then the synchronous table read at that
// slot, then forming the result and writing the slot back; the next transaction is
// taken once the sequencer is back in idle, so one draw finishes before the next is
// accepted. A reseed (func 1) first runs TABLE_DEPTH+8 warm-up steps through the same
// unit, then the draw. A result waiting on the output does not block the next
// transaction from being accepted; the following draw then waits in its final step
// until the output register is free. The integer draw lies in 1..2147483562; divide by
// 2147483563 for the uniform fraction.
module combined_lcg_shuffle_rng #(
    parameter int TABLE_DEPTH = crng_pkg::TABLE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic [30:0]          seed,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [30:0]          draw
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 8);
    localparam logic [CNT_W-1:0] WARM_TOP  = CNT_W'(TABLE_DEPTH + 7);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_WARM_MUL = 7'b0000010,
        ST_WARM_RED = 7'b0000100,
        ST_DRAW_MUL = 7'b0001000,
        ST_DRAW_RED = 7'b0010000,
        ST_DRAW_IDX = 7'b0100000,
        ST_DRAW_RD  = 7'b1000000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    crng_pkg::gen_t      first_gen_reg;
    crng_pkg::gen_t      first_gen_next;
    crng_pkg::gen_t      second_gen_reg;
    crng_pkg::gen_t      second_gen_next;
    crng_pkg::gen_t      last_output_reg;
    crng_pkg::gen_t      last_output_next;
    logic [CNT_W-1:0]    warm_cnt_reg;
    logic [CNT_W-1:0]    warm_cnt_next;
    logic [IDX_W-1:0]    slot_reg;
    logic [IDX_W-1:0]    slot_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    crng_pkg::gen_t      draw_reg;
    crng_pkg::gen_t      draw_next;

    crng_pkg::gen_t      first_step;
    crng_pkg::gen_t      second_step;
    logic [IDX_W-1:0]    slot;
    crng_pkg::tbl_ctrl_t tbl_ctrl;
    logic [IDX_W-1:0]    tbl_wr_addr;
    crng_pkg::gen_t      tbl_wr_data;
    crng_pkg::gen_t      tbl_rd_data;
    logic                out_free;
    logic [32:0]         diff;
    logic [32:0]         diff_wrap;
    crng_pkg::gen_t      draw_res;

    // generator step unit
    crng_gen_unit u_gen (
        .clk         (clk),
        .first_gen   (first_gen_reg),
        .second_gen  (second_gen_reg),
        .first_step  (first_step),
        .second_step (second_step)
    );

    // slot index from previous output
    crng_slot_unit #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_slot (
        .clk         (clk),
        .last_output (last_output_reg),
        .slot        (slot)
    );

    // shuffle table
    crng_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (tbl_ctrl),
        .rd_addr (slot),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_data (tbl_rd_data)
    );

    // result: table entry minus second generator, wrapped into range
    always_comb
    begin
        diff      = {2'b00, tbl_rd_data} - {2'b00, second_gen_reg};
        diff_wrap = diff;
        if (diff[32] || (diff == '0))
        begin
            diff_wrap = diff + {2'b00, crng_pkg::MOD1_LESS1};
        end
        draw_res = diff_wrap[crng_pkg::GEN_W-1:0];
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        first_gen_next   = first_gen_reg;
        second_gen_next  = second_gen_reg;
        last_output_next = last_output_reg;
        warm_cnt_next    = warm_cnt_reg;
        slot_next        = slot_reg;
        draw_next        = draw_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        tbl_ctrl         = '0;
        tbl_wr_addr      = slot_reg;
        tbl_wr_data      = first_gen_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == crng_pkg::FUNC_RESEED)
                    begin
                        first_gen_next = (seed == '0) ? crng_pkg::GEN_W'(1) : seed;
                        warm_cnt_next  = WARM_TOP;
                        state_next     = ST_WARM_MUL;
                    end
                    else
                    begin
                        state_next = ST_DRAW_MUL;
                    end
                end
            end
            ST_WARM_MUL:
            begin
                state_next = ST_WARM_RED;
            end
            ST_WARM_RED:
            begin
                first_gen_next = first_step;
                tbl_wr_addr    = warm_cnt_reg[IDX_W-1:0];
                tbl_wr_data    = first_step;
                tbl_ctrl.wr_en = (warm_cnt_reg < DEPTH_CNT);
                if (warm_cnt_reg == '0)
                begin
                    last_output_next = first_step;
                    state_next       = ST_DRAW_MUL;
                end
                else
                begin
                    warm_cnt_next = warm_cnt_reg - CNT_W'(1);
                    state_next    = ST_WARM_MUL;
                end
            end
            ST_DRAW_MUL:
            begin
                state_next = ST_DRAW_RED;
            end
            ST_DRAW_RED:
            begin
                first_gen_next  = first_step;
                second_gen_next = second_step;
                state_next      = ST_DRAW_IDX;
            end
            ST_DRAW_IDX:
            begin
                tbl_ctrl.rd_en = 1'b1;
                slot_next      = slot;
                state_next     = ST_DRAW_RD;
            end
            ST_DRAW_RD:
            begin
                if (out_free)
                begin
                    tbl_ctrl.wr_en   = 1'b1;
                    out_valid_next   = 1'b1;
                    draw_next        = draw_res;
                    last_output_next = draw_res;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            first_gen_reg   <= '0;
            second_gen_reg  <= crng_pkg::SECOND_RESET;
            last_output_reg <= '0;
            warm_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            first_gen_reg   <= first_gen_next;
            second_gen_reg  <= second_gen_next;
            last_output_reg <= last_output_next;
            warm_cnt_reg    <= warm_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        draw_reg <= draw_next;
    end

    assign out_valid = out_valid_reg;
    assign draw      = draw_reg;

endmodule

// ----- design/crng_checker.sv -----
// port-level checks for the shuffled combined generator, bound to the top level
module crng_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [30:0] draw
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(draw))
    else $error("result changed or dropped while stalled");

    // every draw lies in the generator range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (draw != 31'd0) && (draw <= crng_pkg::MOD1_LESS1))
    else $error("draw out of range");

    // one transaction at a time: input closes after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transaction");

    // a new result only appears while a transaction is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared with no transaction in progress");

endmodule

bind combined_lcg_shuffle_rng crng_checker u_crng_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .draw      (draw)
);
